/* src/egcd_pkg.sv */
// Shared types, constants and helper functions of the extended GCD unit.
package egcd_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DATA_WIDTH);

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAG,
		ST_ORDER,
		ST_DIV,
		ST_UPDATE,
		ST_DONE
	} state_t;

	// Requests from the channel logic to the sequencer.
	typedef struct packed {
		logic start;
		logic take;
	} ctrl_t;

	// Sequencer status seen by the channel logic.
	typedef struct packed {
		logic idle;
		logic done;
	} status_t;

	function automatic word_t negate(word_t v);
		return ~v + word_t'(1);
	endfunction

	function automatic word_t apply_sign(word_t coef, logic neg);
		return neg ? negate(coef) : coef;
	endfunction

endpackage

/* src/extended_gcd_unit_top.sv */
// Top level of the extended GCD unit: input handshake, sequencer and output register.
//
// Usage:
//   Input channel: operand_a and operand_b form one beat, accepted at a rising
//   edge with in_valid high and in_stall low. in_stall is high while an item
//   is being worked on.
//   Output channel: gcd_value, coeff_a and coeff_b form one beat with
//   coeff_a*operand_a + coeff_b*operand_b == gcd_value, taken at an edge with
//   out_valid high and out_stall low. One result beat per input beat.
//   Sequence: the input beat is captured, the magnitudes are formed and
//   ordered, and when either operand is zero the sequencer goes straight to
//   done. Otherwise k Euclid divisions follow; each division is DATA_WIDTH
//   passes of one shared radix-2 step unit plus one coefficient update step.
//   For 32-bit operands k is at most about 46.
//   Throughput: one item at a time; a new beat is taken as soon as the
//   sequencer is back to idle, even if the previous result still waits in the
//   output register.
//   Stall: while out_stall holds a result, the sequencer finishes its next item
//   and then waits with it, keeping in_stall high.
//   Reset: arst_n low clears the sequencer and the output valid flag; no
//   result beat is pending after reset.
module extended_gcd_unit_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [egcd_pkg::DATA_WIDTH-1:0] operand_a,
	input  logic signed [egcd_pkg::DATA_WIDTH-1:0] operand_b,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [egcd_pkg::DATA_WIDTH-1:0] gcd_value,
	output logic signed [egcd_pkg::DATA_WIDTH-1:0] coeff_a,
	output logic signed [egcd_pkg::DATA_WIDTH-1:0] coeff_b
);

	egcd_pkg::ctrl_t   ctrl;
	egcd_pkg::status_t status;
	egcd_pkg::word_t   res_g, res_s, res_t;

	logic            out_valid_q;
	egcd_pkg::word_t gcd_q, coeff_a_q, coeff_b_q;
	logic            load;

	// accept a beat only when the sequencer is idle
	assign in_stall   = ~status.idle;
	assign ctrl.start = in_valid & status.idle;

	// move a finished result into the output register when it is free or draining
	assign load      = status.done & (~out_valid_q | ~out_stall);
	assign ctrl.take = load;

	egcd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.operand_a (egcd_pkg::word_t'(operand_a)),
		.operand_b (egcd_pkg::word_t'(operand_b)),
		.status    (status),
		.res_g     (res_g),
		.res_s     (res_s),
		.res_t     (res_t)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (~out_stall) begin
			// beat taken, drop valid
			out_valid_q <= 1'b0;
		end
	end

	// hold payload while stalled
	always_ff @(posedge clk) begin
		if (load) begin
			gcd_q     <= res_g;
			coeff_a_q <= res_s;
			coeff_b_q <= res_t;
		end
	end

	assign out_valid = out_valid_q;
	assign gcd_value = $signed(gcd_q);
	assign coeff_a   = $signed(coeff_a_q);
	assign coeff_b   = $signed(coeff_b_q);

endmodule

/* src/egcd_step.sv */
// One radix-2 restoring division step with Horner accumulation of quotient times coefficient.
module egcd_step (
	input  egcd_pkg::word_t rem,
	input  logic            num_msb,
	input  egcd_pkg::word_t den,
	input  egcd_pkg::word_t acc_i,
	input  egcd_pkg::word_t acc_j,
	input  egcd_pkg::word_t ci,
	input  egcd_pkg::word_t cj,
	output egcd_pkg::word_t rem_next,
	output egcd_pkg::word_t acc_i_next,
	output egcd_pkg::word_t acc_j_next
);

	localparam int W = egcd_pkg::DATA_WIDTH;

	logic [W:0] cand;
	logic [W:0] diff;
	logic       qbit;

	always_comb begin
		cand = {rem, num_msb};
		diff = cand - {1'b0, den};
		qbit = ~diff[W];
		rem_next = qbit ? diff[W-1:0] : cand[W-1:0];
		// quotient bits arrive MSB first: acc = 2*acc + q*coef
		acc_i_next = {acc_i[W-2:0], 1'b0} + (qbit ? ci : egcd_pkg::word_t'(0));
		acc_j_next = {acc_j[W-2:0], 1'b0} + (qbit ? cj : egcd_pkg::word_t'(0));
	end

endmodule

/* src/egcd_core.sv */
// Sequencer and registers of the extended Euclidean iteration around the shared step unit.
module egcd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  egcd_pkg::ctrl_t   ctrl,
	input  egcd_pkg::word_t   operand_a,
	input  egcd_pkg::word_t   operand_b,
	output egcd_pkg::status_t status,
	output egcd_pkg::word_t   res_g,
	output egcd_pkg::word_t   res_s,
	output egcd_pkg::word_t   res_t
);

	localparam int W = egcd_pkg::DATA_WIDTH;
	localparam egcd_pkg::cnt_t CNT_LAST = egcd_pkg::cnt_t'(W - 1);

	egcd_pkg::state_t state_q, state_d;
	egcd_pkg::cnt_t   cnt_q;

	egcd_pkg::word_t a_q, b_q, ma_q, mb_q;
	logic            a_big_q;
	egcd_pkg::word_t num_q, den_q, rem_q;
	egcd_pkg::word_t px_q, py_q, ci_q, cj_q, acc_i_q, acc_j_q;
	egcd_pkg::word_t res_g_q, res_s_q, res_t_q;

	egcd_pkg::word_t rem_next, acc_i_next, acc_j_next;
	logic            a_zero, b_zero;

	assign a_zero = (a_q == '0);
	assign b_zero = (b_q == '0);

	egcd_step u_step (
		.rem        (rem_q),
		.num_msb    (num_q[W-1]),
		.den        (den_q),
		.acc_i      (acc_i_q),
		.acc_j      (acc_j_q),
		.ci         (ci_q),
		.cj         (cj_q),
		.rem_next   (rem_next),
		.acc_i_next (acc_i_next),
		.acc_j_next (acc_j_next)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			egcd_pkg::ST_IDLE: begin
				if (ctrl.start) state_d = egcd_pkg::ST_MAG;
			end
			egcd_pkg::ST_MAG: begin
				state_d = egcd_pkg::ST_ORDER;
			end
			egcd_pkg::ST_ORDER: begin
				state_d = (a_zero || b_zero) ? egcd_pkg::ST_DONE : egcd_pkg::ST_DIV;
			end
			egcd_pkg::ST_DIV: begin
				if (cnt_q == '0) state_d = egcd_pkg::ST_UPDATE;
			end
			egcd_pkg::ST_UPDATE: begin
				state_d = (rem_q == '0) ? egcd_pkg::ST_DONE : egcd_pkg::ST_DIV;
			end
			egcd_pkg::ST_DONE: begin
				if (ctrl.take) state_d = egcd_pkg::ST_IDLE;
			end
			default: begin
				state_d = egcd_pkg::ST_IDLE;
			end
		endcase
	end

	// status outputs
	always_comb begin
		status.idle = (state_q == egcd_pkg::ST_IDLE);
		status.done = (state_q == egcd_pkg::ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= egcd_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == egcd_pkg::ST_ORDER || state_q == egcd_pkg::ST_UPDATE) begin
				cnt_q <= CNT_LAST;
			end else if (state_q == egcd_pkg::ST_DIV) begin
				cnt_q <= cnt_q - egcd_pkg::cnt_t'(1);
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			egcd_pkg::ST_IDLE: begin
				if (ctrl.start) begin
					a_q <= operand_a;
					b_q <= operand_b;
				end
			end
			egcd_pkg::ST_MAG: begin
				ma_q <= a_q[W-1] ? egcd_pkg::negate(a_q) : a_q;
				mb_q <= b_q[W-1] ? egcd_pkg::negate(b_q) : b_q;
			end
			egcd_pkg::ST_ORDER: begin
				if (a_zero) begin
					res_g_q <= b_q;
					res_s_q <= '0;
					res_t_q <= b_zero ? egcd_pkg::word_t'(0) : egcd_pkg::word_t'(1);
				end else if (b_zero) begin
					res_g_q <= a_q;
					res_s_q <= egcd_pkg::word_t'(1);
					res_t_q <= '0;
				end
				a_big_q <= (ma_q >= mb_q);
				num_q   <= (ma_q >= mb_q) ? ma_q : mb_q;
				den_q   <= (ma_q >= mb_q) ? mb_q : ma_q;
				rem_q   <= '0;
				px_q    <= egcd_pkg::word_t'(1);
				py_q    <= '0;
				ci_q    <= '0;
				cj_q    <= egcd_pkg::word_t'(1);
				acc_i_q <= '0;
				acc_j_q <= '0;
			end
			egcd_pkg::ST_DIV: begin
				rem_q   <= rem_next;
				num_q   <= {num_q[W-2:0], 1'b0};
				acc_i_q <= acc_i_next;
				acc_j_q <= acc_j_next;
			end
			egcd_pkg::ST_UPDATE: begin
				if (rem_q == '0) begin
					res_g_q <= den_q;
					res_s_q <= egcd_pkg::apply_sign(a_big_q ? ci_q : cj_q, a_q[W-1]);
					res_t_q <= egcd_pkg::apply_sign(a_big_q ? cj_q : ci_q, b_q[W-1]);
				end else begin
					num_q   <= den_q;
					den_q   <= rem_q;
					rem_q   <= '0;
					px_q    <= ci_q;
					py_q    <= cj_q;
					ci_q    <= px_q - acc_i_q;
					cj_q    <= py_q - acc_j_q;
					acc_i_q <= '0;
					acc_j_q <= '0;
				end
			end
			egcd_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign res_g = res_g_q;
	assign res_s = res_s_q;
	assign res_t = res_t_q;

	// partial remainder stays below a nonzero divisor throughout division
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == egcd_pkg::ST_DIV |-> (den_q != '0) && (rem_q < den_q))
		else $error("partial remainder not below divisor");

	a_start_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> state_q == egcd_pkg::ST_IDLE)
		else $error("start outside idle");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == egcd_pkg::ST_DIV && cnt_q == '0 |=> state_q == egcd_pkg::ST_UPDATE)
		else $error("division pass did not end after its last step");

	a_take_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.take |-> state_q == egcd_pkg::ST_DONE)
		else $error("result taken while none is ready");

endmodule
